>>> sv/route_segment_table_unit_defines.svh
// Assertion macros for the route segment table RTL.
`ifndef ROUTE_SEGMENT_TABLE_UNIT_DEFINES_SVH
`define ROUTE_SEGMENT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RSEG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define RSEG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RSEG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RSEG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> sv/rseg_pkg.sv
// Types, codes and helper functions for the route segment table.
`default_nettype none

package rseg_pkg;

  localparam int TABLE_DEPTH_DEF  = 32;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int          ATTR_PAIRS  = 5;
  localparam logic [3:0]  ATTR_SEP_ID = 4'd4;

  localparam logic [1:0] FUNC_PUSH  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_INCOMPLETE = 3'd2,
    ST_FULL       = 3'd3,
    ST_CLEARED    = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_UPDATED    = 3'd6
  } rseg_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } rseg_state_t;

  // Table commands issued by the sequencer.
  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic ins_en;
  } rseg_tbl_cmd_t;

  // Compare result of the entry read in the previous cycle.
  typedef struct packed {
    logic hit_valid;
    logic hit;
  } rseg_tbl_stat_t;

  // First attribute pair carrying the separation id wins; otherwise fall back.
  function automatic logic [3:0] pick_separation(input logic [19:0] ids,
                                                 input logic [19:0] vals,
                                                 input logic [3:0]  fallback);
    logic [3:0] res;
    res = fallback;
    for (int k = ATTR_PAIRS - 1; k >= 0; k--) begin
      if (ids[4*k +: 4] == ATTR_SEP_ID) begin
        res = vals[4*k +: 4];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> sv/rseg_entry_table.sv
// Entry memory with registered read, id compare, insert and separation write-back.
`default_nettype none

module rseg_entry_table
  import rseg_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rseg_tbl_cmd_t           cmd,
  input  wire logic [AW-1:0]           rd_addr,
  input  wire logic [7:0]              key_id,
  input  wire logic [3:0]              new_sep,
  input  wire logic [AW-1:0]           ins_addr,
  input  wire logic [PAYLOAD_BITS-1:0] ins_data,
  output rseg_tbl_stat_t               stat
);

  typedef struct packed {
    logic [7:0]              id;
    logic [3:0]              sep;
    logic [PAYLOAD_BITS-1:0] data;
  } rseg_word_t;

  rseg_word_t mem [TABLE_DEPTH];

  rseg_word_t    rd_word;
  logic [AW-1:0] rd_tag;
  logic          rd_valid;
  logic          hit;

  assign hit            = rd_valid && (rd_word.id == key_id);
  assign stat.hit_valid = rd_valid;
  assign stat.hit       = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
    end
  end

  // Write-back always targets an address older than the one being read,
  // and inserts happen only with no read in flight, so no forwarding.
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_word <= mem[rd_addr];
      rd_tag  <= rd_addr;
    end
    if (cmd.ins_en) begin
      mem[ins_addr] <= '{id: key_id, sep: new_sep, data: ins_data};
    end else if (cmd.upd_en && hit) begin
      mem[rd_tag] <= '{id: rd_word.id, sep: new_sep, data: rd_word.data};
    end
  end

endmodule

`default_nettype wire

>>> sv/route_segment_table_unit.sv
// Route segment table: sequencer, output register and top-level ports.
//
// Input channel s_*: one command per transfer. s_tuser carries func
// (push, clear, attribute update); s_tdata carries the segment fields.
// Output channel m_*: one result per command. m_tuser carries the status
// code, m_tdata the entry count, match count and separation in force.
//
// A push or update walks the held entries through the entry memory, one
// read per cycle through its registered read port, and takes a new command
// only after the walk and its last step are done; a clear skips the walk.
// The walk over the memory read port sets how long a push or update takes.
//
// The result sits in an output register; the next command is accepted
// while it waits. If the receiver stalls, a finished command holds in its
// last step until the output register frees up, and s_tready stays low.
//
// Reset empties the table (fill count zero) and zeroes the separation in
// force; memory contents are not cleared and need no clearing pass.
`default_nettype none

`include "route_segment_table_unit_defines.svh"

module route_segment_table_unit
  import rseg_pkg::*;
#(
  parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // seg_id[7:0], complete[8], separation[12:9], payload[44:13],
  // attr_ids[64:45], attr_vals[84:65], zero pad[87:85]
  input  wire logic [87:0] s_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // entry_count[5:0], matched[11:6], chosen_separation[15:12]
  output logic [15:0]      m_tdata,
  // status[2:0]
  output logic [2:0]       m_tuser
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  rseg_state_t state, state_next;

  logic [1:0]              func_q;
  logic [7:0]              sid_q;
  logic                    complete_q;
  logic [3:0]              sep_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic [3:0]              chosen_q;

  logic [CW-1:0] fill, fill_next;
  logic [3:0]    cur_sep, cur_sep_next;
  logic [CW-1:0] rd_idx;
  logic          dup;
  logic [CW-1:0] matched;

  logic         out_valid;
  rseg_status_t out_status;
  logic [5:0]   out_count;
  logic [5:0]   out_matched;
  logic [3:0]   out_sep;

  logic           accept, is_upd, is_clear, scan_done, finish_go;
  rseg_status_t   fin_status;
  rseg_tbl_cmd_t  tbl_cmd;
  rseg_tbl_stat_t tbl_stat;

  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign is_upd    = func_q[1];
  assign is_clear  = (func_q == FUNC_CLEAR);
  assign scan_done = (rd_idx >= fill) && !tbl_stat.hit_valid;
  assign finish_go = (state == S_FINISH) && (!out_valid || m_tready);

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {out_sep, out_matched, out_count};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == FUNC_CLEAR) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Result decision, table commands, and next fill count and separation.
  always_comb begin
    priority if (is_upd) begin
      fin_status = ST_UPDATED;
    end else if (is_clear) begin
      fin_status = (fill == '0) ? ST_EMPTY : ST_CLEARED;
    end else if (dup) begin
      fin_status = ST_DUPLICATE;
    end else if (!complete_q) begin
      fin_status = ST_INCOMPLETE;
    end else if (fill >= CW'(TABLE_DEPTH)) begin
      fin_status = ST_FULL;
    end else begin
      fin_status = ST_INSERTED;
    end

    tbl_cmd.rd_en  = (state == S_SCAN) && (rd_idx < fill);
    tbl_cmd.upd_en = (state == S_SCAN) && is_upd;
    tbl_cmd.ins_en = finish_go && (fin_status == ST_INSERTED);

    fill_next    = fill;
    cur_sep_next = cur_sep;
    if (finish_go) begin
      if (fin_status == ST_CLEARED) begin
        fill_next = '0;
      end else if (fin_status == ST_INSERTED) begin
        fill_next = fill + CW'(1);
      end
      if (is_upd) begin
        cur_sep_next = chosen_q;
      end else if (!is_clear) begin
        cur_sep_next = sep_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cur_sep   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      cur_sep <= cur_sep_next;
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the command, advance the walk, collect compare results and register the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q     <= s_tuser;
      sid_q      <= s_tdata[7:0];
      complete_q <= s_tdata[8];
      sep_q      <= s_tdata[12:9];
      payload_q  <= PAYLOAD_BITS'(s_tdata[44:13]);
      chosen_q   <= pick_separation(s_tdata[64:45], s_tdata[84:65], s_tdata[12:9]);
      rd_idx     <= '0;
      dup        <= 1'b0;
      matched    <= '0;
    end else if (state == S_SCAN) begin
      if (tbl_cmd.rd_en) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (tbl_stat.hit_valid && tbl_stat.hit) begin
        dup     <= 1'b1;
        matched <= matched + CW'(1);
      end
    end
    if (finish_go) begin
      out_status  <= fin_status;
      out_count   <= 6'(fill_next);
      out_matched <= is_upd ? 6'(matched) : 6'd0;
      out_sep     <= cur_sep_next;
    end
  end

  rseg_entry_table #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .cmd      (tbl_cmd),
    .rd_addr  (rd_idx[AW-1:0]),
    .key_id   (sid_q),
    .new_sep  (is_upd ? chosen_q : sep_q),
    .ins_addr (fill[AW-1:0]),
    .ins_data (payload_q),
    .stat     (tbl_stat)
  );

  `RSEG_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CW'(TABLE_DEPTH), "fill count above depth")
  `RSEG_ASSERT_IMP(a_hit_in_scan, clk, rst, tbl_stat.hit_valid, state == S_SCAN, "compare result outside walk")
  `RSEG_ASSERT_IMP(a_walk_bound, clk, rst, state == S_SCAN, rd_idx <= fill, "walk ran past held entries")
  `RSEG_ASSERT_NXT(a_insert_grows, clk, rst, tbl_cmd.ins_en, fill == $past(fill) + CW'(1), "insert did not grow table")

endmodule

`default_nettype wire

>>> tb/tb_route_segment_table_unit.sv
// Testbench for route_segment_table_unit: directed and random commands checked against a predictor.
module tb_route_segment_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rseg_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;
  // Bit 1 alone selects an update, so the fourth code updates too.
  localparam logic [1:0] FUNC_UPDATE_ALT = 2'd3;
  localparam int MAX_GAP = 19;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  func;
    logic [7:0]  seg_id;
    logic        complete;
    logic [3:0]  separation;
    logic [31:0] payload;
    logic [19:0] attr_ids;
    logic [19:0] attr_vals;
  } seg_cmd_t;

  typedef struct {
    rseg_status_t status;
    logic [5:0]   entry_count;
    logic [5:0]   matched;
    logic [3:0]   chosen_sep;
  } seg_res_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;

  // Mirror of the segment table: only held ids and the separation in force are visible.
  logic [7:0] tbl_ids [DEPTH];
  int         tbl_fill;
  logic [3:0] sep_in_force;

  seg_res_t pending_results[$];
  int       fails;
  int       cycles;
  bit       no_idle;

  route_segment_table_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_route_segment_table_unit NOT OK");
      $finish;
    end
  end

  function automatic bit id_held(logic [7:0] id);
    for (int i = 0; i < tbl_fill; i++) begin
      if (tbl_ids[i] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic seg_res_t predict_cmd(seg_cmd_t c);
    seg_res_t   r;
    logic [3:0] chosen;
    bit         found;
    int         hits;
    hits = 0;
    if (c.func[1]) begin
      chosen = c.separation;
      found = 1'b0;
      for (int k = 0; k < ATTR_PAIRS; k++) begin
        if (!found && c.attr_ids[4*k +: 4] == ATTR_SEP_ID) begin
          chosen = c.attr_vals[4*k +: 4];
          found = 1'b1;
        end
      end
      sep_in_force = chosen;
      for (int i = 0; i < tbl_fill; i++) begin
        if (tbl_ids[i] == c.seg_id) hits++;
      end
      r.status = ST_UPDATED;
    end else if (c.func == FUNC_CLEAR) begin
      if (tbl_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        tbl_fill = 0;
        r.status = ST_CLEARED;
      end
    end else begin
      // Duplicate check first, then completeness, then room.
      sep_in_force = c.separation;
      if (id_held(c.seg_id)) begin
        r.status = ST_DUPLICATE;
      end else if (!c.complete) begin
        r.status = ST_INCOMPLETE;
      end else if (tbl_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        tbl_ids[tbl_fill] = c.seg_id;
        tbl_fill++;
        r.status = ST_INSERTED;
      end
    end
    r.entry_count = 6'(tbl_fill);
    r.matched = 6'(hits);
    r.chosen_sep = sep_in_force;
    return r;
  endfunction

  function automatic seg_cmd_t mk_cmd(logic [1:0] func, logic [7:0] id, logic complete,
                                      logic [3:0] sep, logic [31:0] payload,
                                      logic [19:0] ids, logic [19:0] vals);
    seg_cmd_t c;
    c.func = func;
    c.seg_id = id;
    c.complete = complete;
    c.separation = sep;
    c.payload = payload;
    c.attr_ids = ids;
    c.attr_vals = vals;
    return c;
  endfunction

  function automatic logic [19:0] rand_attr_ids();
    logic [19:0] ids;
    int          k;
    ids = 20'($urandom);
    k = $urandom_range(0, ATTR_PAIRS - 1);
    if ($urandom_range(0, 2) != 0) ids[4*k +: 4] = ATTR_SEP_ID;
    return ids;
  endfunction

  function automatic seg_cmd_t rand_cmd(int id_span, int clear_pct);
    seg_cmd_t c;
    int       p;
    p = $urandom_range(0, 99);
    if (p < clear_pct) begin
      c.func = FUNC_CLEAR;
    end else if (p < clear_pct + 30) begin
      c.func = $urandom_range(0, 1) ? FUNC_UPDATE : FUNC_UPDATE_ALT;
    end else begin
      c.func = FUNC_PUSH;
    end
    if ($urandom_range(0, 3) == 0) begin
      c.seg_id = 8'($urandom);
    end else begin
      c.seg_id = 8'($urandom_range(0, id_span));
    end
    // Aim most updates at held ids so that entries get rewritten.
    if (c.func[1] && tbl_fill > 0 && $urandom_range(0, 2) != 0) begin
      c.seg_id = tbl_ids[$urandom_range(0, tbl_fill - 1)];
    end
    c.complete = ($urandom_range(0, 9) != 0);
    c.separation = 4'($urandom);
    c.payload = $urandom;
    c.attr_ids = rand_attr_ids();
    c.attr_vals = 20'($urandom);
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(seg_cmd_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.func;
    s_tdata <= {3'b000, c.attr_vals, c.attr_ids, c.payload, c.separation, c.complete,
                c.seg_id};
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_cmd(c));
    @(negedge clk);
  endtask

  // Hold the sender until every pending result has been taken.
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_result();
    seg_res_t want;
    if (pending_results.size() == 0) begin
      fails++;
      $error("result transfer with no pending command: status %0d", m_tuser);
    end else begin
      want = pending_results.pop_front();
      cmp_field("status", want.status, m_tuser);
      cmp_field("entry_count", want.entry_count, m_tdata[5:0]);
      cmp_field("matched", want.matched, m_tdata[11:6]);
      cmp_field("chosen_separation", want.chosen_sep, m_tdata[15:12]);
    end
  endtask

  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result();
      @(negedge clk);
    end
  end

  task automatic test_push_rules();
    send_cmd(mk_cmd(FUNC_PUSH, 8'd0, 1'b1, 4'hF, 32'hFFFF_FFFF, 20'h00000, 20'h00000));
    send_cmd(mk_cmd(FUNC_PUSH, 8'd255, 1'b1, 4'h0, 32'h0, 20'hFFFFF, 20'hFFFFF));
    send_cmd(mk_cmd(FUNC_PUSH, 8'd0, 1'b1, 4'h5, 32'h1234_5678, 20'h0, 20'h0));
    // Duplicate wins over incomplete.
    send_cmd(mk_cmd(FUNC_PUSH, 8'd0, 1'b0, 4'hA, 32'h0, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_PUSH, 8'd9, 1'b0, 4'h3, 32'hA5A5_A5A5, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_PUSH, 8'd9, 1'b1, 4'hC, 32'h5A5A_5A5A, 20'h0, 20'h0));
  endtask

  task automatic test_clear_rules();
    send_cmd(mk_cmd(FUNC_CLEAR, 8'd0, 1'b0, 4'h0, 32'h0, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_CLEAR, 8'd0, 1'b1, 4'h7, 32'h0, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_PUSH, 8'd1, 1'b1, 4'h2, 32'h0000_0001, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_PUSH, 8'd255, 1'b1, 4'h6, 32'h8000_0000, 20'h0, 20'h0));
  endtask

  task automatic test_attr_update();
    send_cmd(mk_cmd(FUNC_UPDATE, 8'd1, 1'b0, 4'h1, 32'h0, 20'h00004, 20'h0000A));
    send_cmd(mk_cmd(FUNC_UPDATE, 8'd1, 1'b0, 4'h1, 32'h0, 20'h41235, 20'hC0000));
    // First matching pair wins.
    send_cmd(mk_cmd(FUNC_UPDATE, 8'd255, 1'b1, 4'h0, 32'h0, 20'h44444, 20'h12345));
    send_cmd(mk_cmd(FUNC_UPDATE, 8'd1, 1'b0, 4'h0, 32'h0, 20'h04400, 20'h09800));
    // No pair carries the separation id: fall back to the record's code.
    send_cmd(mk_cmd(FUNC_UPDATE, 8'd1, 1'b0, 4'h3, 32'h0, 20'h00000, 20'hFFFFF));
    send_cmd(mk_cmd(FUNC_UPDATE_ALT, 8'd255, 1'b0, 4'hE, 32'h0, 20'hFFFF4, 20'h0000F));
    send_cmd(mk_cmd(FUNC_UPDATE, 8'd77, 1'b1, 4'h9, 32'h0, 20'hFFFFF, 20'h00000));
    send_cmd(mk_cmd(FUNC_CLEAR, 8'd0, 1'b0, 4'h0, 32'h0, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_UPDATE_ALT, 8'd1, 1'b0, 4'hB, 32'h0, 20'h40000, 20'h70000));
  endtask

  task automatic test_table_full();
    logic [7:0] id;
    send_cmd(mk_cmd(FUNC_CLEAR, 8'($urandom), 1'b0, 4'($urandom), $urandom, 20'h0, 20'h0));
    while (tbl_fill < DEPTH) begin
      do id = 8'($urandom); while (id_held(id));
      send_cmd(mk_cmd(FUNC_PUSH, id, 1'b1, 4'($urandom), $urandom, rand_attr_ids(),
                      20'($urandom)));
    end
    do id = 8'($urandom); while (id_held(id));
    send_cmd(mk_cmd(FUNC_PUSH, id, 1'b1, 4'($urandom), $urandom, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_PUSH, tbl_ids[$urandom_range(0, DEPTH - 1)], 1'b1, 4'($urandom),
                    $urandom, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_PUSH, id, 1'b0, 4'($urandom), $urandom, 20'h0, 20'h0));
    send_cmd(mk_cmd(FUNC_UPDATE, tbl_ids[DEPTH - 1], 1'b0, 4'($urandom), 32'h0,
                    rand_attr_ids(), 20'($urandom)));
    send_cmd(mk_cmd(FUNC_CLEAR, 8'd0, 1'b0, 4'h0, 32'h0, 20'h0, 20'h0));
  endtask

  task automatic test_paused_sender();
    repeat (2) begin
      repeat (10) send_cmd(rand_cmd(31, 5));
      wait_drain();
    end
  endtask

  task automatic test_random_mix();
    int id_span;
    int clear_pct;
    repeat (18) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: id_span = 15;
        1: id_span = 63;
        default: id_span = 255;
      endcase
      case ($urandom_range(0, 2))
        0: clear_pct = 0;
        1: clear_pct = 2;
        default: clear_pct = 6;
      endcase
      repeat (50) send_cmd(rand_cmd(id_span, clear_pct));
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_PUSH;
    no_idle = 1'b0;
    fails = 0;
    cycles = 0;
    tbl_fill = 0;
    sep_in_force = 4'h0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_push_rules();
    test_clear_rules();
    test_attr_update();
    test_table_full();
    test_paused_sender();
    test_random_mix();
    test_table_full();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("tb_route_segment_table_unit OK");
    end else begin
      $display("tb_route_segment_table_unit NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rseg_pkg.sv
sv/rseg_entry_table.sv
sv/route_segment_table_unit.sv
tb/tb_route_segment_table_unit.sv
